// ----- rtl/core/dpu_pkg.sv -----
// Shared types and constants for the bitmap pixel unpack and nearest-neighbor scaler.
// Used by every module in rtl/core; depends on nothing else.
package dpu_pkg;

  localparam int unsigned MILLI      = 1000;
  localparam int unsigned MAX_ROW_PX = 1024;
  localparam int unsigned PAL_AW     = 8;
  localparam int unsigned PAL_DEPTH  = 256;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    REQ_PAL   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    FMT_1BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_8BPP  = 3'd2,
    FMT_24BPP = 3'd3,
    FMT_32BPP = 3'd4
  } fmt_e;

  typedef enum logic [2:0] {
    CFG_FORMAT     = 3'd0,
    CFG_SRC_WIDTH  = 3'd1,
    CFG_ZOOM       = 3'd2,
    CFG_OUT_WIDTH  = 3'd3,
    CFG_OUT_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [10:0] src_width;
    logic [13:0] zoom;
    logic [10:0] out_width;
    logic [10:0] out_height;
  } cfg_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        eor;
    logic        eoi;
  } pixel_t;

  // One pixel leaving the unpacker: either a palette lookup or a direct color.
  typedef struct packed {
    logic              valid;
    logic              from_pal;
    logic [PAL_AW-1:0] addr;
    pixel_t            pix;
  } pix_req_t;

endpackage

// ----- rtl/core/dpu_palette_ram.sv -----
// Palette memory: one write port, one read port with registered read data.
// Depends on dpu_pkg.
module dpu_palette_ram
  import dpu_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [PAL_AW-1:0] waddr_i,
  input  logic [23:0]       wdata_i,
  input  logic              re_i,
  input  logic [PAL_AW-1:0] raddr_i,
  output logic [23:0]       rdata_o
);

  logic [23:0] mem_q [PAL_DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read in the same cycle as a write to the same entry returns the old value.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dpu_unpack.sv -----
// Byte unpacker: walks pixels of each row byte, decimates rows and columns,
// and issues palette reads or direct colors. Depends on dpu_pkg.
module dpu_unpack
  import dpu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        palette_index_i,
  input  logic [7:0]        palette_red_i,
  input  logic [7:0]        palette_green_i,
  input  logic [7:0]        palette_blue_i,
  input  logic [7:0]        data_byte_i,
  input  logic              issue_ok_i,
  output logic              pal_we_o,
  output logic [PAL_AW-1:0] pal_waddr_o,
  output logic [23:0]       pal_wdata_o,
  output pix_req_t          req_o
);

  localparam logic signed [15:0] MilliS = 16'(MILLI);

  logic              s_v_q, s_v_d;
  logic [7:0]        s_byte_q, s_byte_d;
  logic [2:0]        s_k_q, s_k_d;
  logic [11:0]       rbc_q, rbc_d;
  logic [1:0]        rmod3_q, rmod3_d;
  logic [10:0]       spc_q, spc_d;
  logic [15:0]       part_q, part_d;
  logic signed [15:0] col_q, col_d;
  logic signed [15:0] rowacc_q, rowacc_d;
  logic              rowsel_q, rowsel_d;
  logic [10:0]       occ_q, occ_d;
  logic [10:0]       orc_q, orc_d;

  logic [2:0]        fmt;
  logic [10:0]       width;
  logic [13:0]       zoom;
  logic signed [15:0] zoom_s;
  logic [12:0]       w13, data_bytes, row_bytes, r13;
  logic              in_data, direct_fmt, has_pix, is_last, step, emit, accept;
  logic [2:0]        last_k;
  logic [7:0]        pal_idx;
  logic signed [15:0] col_m, row_tmp;

  // Effective configuration: out-of-range values are clamped; an unknown format gives 8 bpp.
  always_comb begin
    fmt   = (cfg_i.fmt > FMT_32BPP) ? FMT_8BPP : cfg_i.fmt;
    width = (cfg_i.src_width == 11'd0) ? 11'd1 :
            (cfg_i.src_width > 11'(MAX_ROW_PX)) ? 11'(MAX_ROW_PX) : cfg_i.src_width;
    zoom  = (cfg_i.zoom < 14'(MILLI)) ? 14'(MILLI) : cfg_i.zoom;
    zoom_s = signed'({2'b00, zoom});
    w13   = {2'b00, width};
    case (fmt)
      FMT_1BPP:  data_bytes = (w13 + 13'd7) >> 3;
      FMT_4BPP:  data_bytes = (w13 + 13'd1) >> 1;
      FMT_24BPP: data_bytes = (w13 << 1) + w13;
      FMT_32BPP: data_bytes = w13 << 2;
      default:   data_bytes = w13;
    endcase
    row_bytes = (data_bytes + 13'd3) & ~13'd3;
  end

  assign r13        = {1'b0, rbc_q};
  assign in_data    = r13 < data_bytes;
  assign direct_fmt = (fmt == FMT_24BPP) || (fmt == FMT_32BPP);
  assign last_k     = (in_data && fmt == FMT_1BPP) ? 3'd7 :
                      (in_data && fmt == FMT_4BPP) ? 3'd1 : 3'd0;
  assign is_last    = s_k_q == last_k;
  assign step       = s_v_q && issue_ok_i;
  assign in_stall_o = s_v_q && !(step && is_last);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (fmt)
      FMT_1BPP: pal_idx = {7'd0, s_byte_q[3'd7 - s_k_q]};
      FMT_4BPP: pal_idx = s_k_q[0] ? {4'd0, s_byte_q[3:0]} : {4'd0, s_byte_q[7:4]};
      default:  pal_idx = s_byte_q;
    endcase
    if (fmt == FMT_24BPP) begin
      has_pix = in_data && (rmod3_q == 2'd2);
    end else if (fmt == FMT_32BPP) begin
      has_pix = in_data && (rbc_q[1:0] == 2'd3);
    end else begin
      has_pix = in_data;
    end
  end

  always_comb begin
    s_v_d    = s_v_q;
    s_byte_d = s_byte_q;
    s_k_d    = s_k_q;
    rbc_d    = rbc_q;
    rmod3_d  = rmod3_q;
    spc_d    = spc_q;
    part_d   = part_q;
    col_d    = col_q;
    rowacc_d = rowacc_q;
    rowsel_d = rowsel_q;
    occ_d    = occ_q;
    orc_d    = orc_q;
    emit     = 1'b0;
    col_m    = col_q - MilliS;
    row_tmp  = rowacc_q + (rowsel_q ? zoom_s : 16'sd0) - MilliS;
    pal_we_o = 1'b0;

    if (step) begin
      if (has_pix && spc_q < width) begin
        spc_d = spc_q + 11'd1;
        if (rowsel_q && orc_q < cfg_i.out_height) begin
          if (col_m[15]) begin
            if (occ_q < cfg_i.out_width) begin
              emit  = 1'b1;
              occ_d = occ_q + 11'd1;
            end
            col_d = col_m + zoom_s;
          end else begin
            col_d = col_m;
          end
        end
      end
      if (in_data && direct_fmt) begin
        part_d = {part_q[7:0], s_byte_q};
      end
      if (is_last) begin
        s_v_d = 1'b0;
        s_k_d = 3'd0;
        if (r13 + 13'd1 >= row_bytes) begin
          if (rowsel_q && orc_q < cfg_i.out_height) begin
            orc_d = orc_q + 11'd1;
          end
          rowacc_d = row_tmp;
          rowsel_d = row_tmp[15] || (row_tmp == 16'sd0);
          rbc_d    = 12'd0;
          rmod3_d  = 2'd0;
          spc_d    = 11'd0;
          part_d   = 16'd0;
          col_d    = 16'sd0;
          occ_d    = 11'd0;
        end else begin
          rbc_d   = rbc_q + 12'd1;
          rmod3_d = (rmod3_q == 2'd2) ? 2'd0 : rmod3_q + 2'd1;
        end
      end else begin
        s_k_d = s_k_q + 3'd1;
      end
    end

    if (accept) begin
      case (req_type_e'(req_type_i))
        REQ_PAL: pal_we_o = 1'b1;
        REQ_DATA: begin
          s_v_d    = 1'b1;
          s_byte_d = data_byte_i;
          s_k_d    = 3'd0;
        end
        REQ_CLEAR: begin
          rbc_d    = 12'd0;
          rmod3_d  = 2'd0;
          spc_d    = 11'd0;
          part_d   = 16'd0;
          col_d    = 16'sd0;
          rowacc_d = 16'sd0;
          rowsel_d = 1'b1;
          occ_d    = 11'd0;
          orc_d    = 11'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q    <= 1'b0;
      s_k_q    <= 3'd0;
      rbc_q    <= 12'd0;
      rmod3_q  <= 2'd0;
      spc_q    <= 11'd0;
      part_q   <= 16'd0;
      col_q    <= 16'sd0;
      rowacc_q <= 16'sd0;
      rowsel_q <= 1'b1;
      occ_q    <= 11'd0;
      orc_q    <= 11'd0;
    end else begin
      s_v_q    <= s_v_d;
      s_k_q    <= s_k_d;
      rbc_q    <= rbc_d;
      rmod3_q  <= rmod3_d;
      spc_q    <= spc_d;
      part_q   <= part_d;
      col_q    <= col_d;
      rowacc_q <= rowacc_d;
      rowsel_q <= rowsel_d;
      occ_q    <= occ_d;
      orc_q    <= orc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_byte_q <= s_byte_d;
  end

  assign pal_waddr_o = palette_index_i;
  assign pal_wdata_o = {palette_red_i, palette_green_i, palette_blue_i};

  always_comb begin
    req_o.valid    = emit;
    req_o.from_pal = !direct_fmt;
    req_o.addr     = pal_idx;
    // Direct color: newest byte is red, the one before green, the oldest blue.
    req_o.pix.rgb  = {s_byte_q, part_q[7:0], part_q[15:8]};
    req_o.pix.eor  = occ_q == (cfg_i.out_width - 11'd1);
    req_o.pix.eoi  = req_o.pix.eor && (orc_q == (cfg_i.out_height - 11'd1));
  end

endmodule

// ----- rtl/core/dpu_out_fifo.sv -----
// Small output queue that decouples pixel issue from the downstream stall.
// Depends on dpu_pkg.
module dpu_out_fifo
  import dpu_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pixel_t         data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pixel_t         data_o,
  output logic [FIFO_AW:0] count_o
);

  pixel_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               pop;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign data_o      = mem_q[rptr_q];
  assign count_o     = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != (FIFO_AW+1)'(FIFO_DEPTH) || pop))
    else $error("output queue overflow");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not rise on push");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- rtl/core/dib_pixel_unpack_nearest_scaler_unit.sv -----
// Top level of the bitmap pixel unpacker with palette expansion and shrink.
// Depends on dpu_pkg, dpu_palette_ram, dpu_unpack and dpu_out_fifo.
//
//  Channel | Handshake               | Beat contents
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | req_type, palette index and color, data byte
//  out     | out_valid_o/out_stall_i | red, green, blue, end_of_row, end_of_image
//  cfg     | cfg_valid_i/cfg_ready_o | register index, write data
//
// An 8, 24 or 32 bpp byte gives one pixel slot, a 4 bpp byte two, a 1 bpp byte
// eight. Slots step one per cycle while the output queue has room; the next byte
// is taken as the last slot of the current one steps. A selected pixel passes the
// palette read stage, then the output queue. Reset clears all control state; the
// palette holds garbage until written. On a downstream stall the unpacker holds its
// byte while the four-beat queue plus the in-flight pixel exceed two beats.
module dib_pixel_unpack_nearest_scaler_unit
  import dpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  palette_index_i,
  input  logic [7:0]  palette_red_i,
  input  logic [7:0]  palette_green_i,
  input  logic [7:0]  palette_blue_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        end_of_row_o,
  output logic        end_of_image_o
);

  cfg_t              cfg_q;
  pix_req_t          req;
  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr;
  logic [23:0]       pal_wdata, pal_rdata;
  logic              p1_v_q, p1_pal_q;
  pixel_t            p1_pix_q, push_pix, head;
  logic [FIFO_AW:0]  fifo_count;
  logic              issue_ok;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt        <= FMT_8BPP;
      cfg_q.src_width  <= 11'd1;
      cfg_q.zoom       <= 14'(MILLI);
      cfg_q.out_width  <= 11'd1;
      cfg_q.out_height <= 11'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FORMAT:     cfg_q.fmt        <= cfg_data_i[2:0];
        CFG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i[10:0];
        CFG_ZOOM:       cfg_q.zoom       <= cfg_data_i;
        CFG_OUT_WIDTH:  cfg_q.out_width  <= cfg_data_i[10:0];
        CFG_OUT_HEIGHT: cfg_q.out_height <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // A slot may proceed only if the queue can absorb whatever is in flight plus
  // the pixel this slot might produce.
  assign issue_ok = ({1'b0, fifo_count} + {{(FIFO_AW+1){1'b0}}, p1_v_q})
                    <= (FIFO_AW+2)'(FIFO_DEPTH - 2);

  dpu_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .palette_index_i (palette_index_i),
    .palette_red_i   (palette_red_i),
    .palette_green_i (palette_green_i),
    .palette_blue_i  (palette_blue_i),
    .data_byte_i     (data_byte_i),
    .issue_ok_i      (issue_ok),
    .pal_we_o        (pal_we),
    .pal_waddr_o     (pal_waddr),
    .pal_wdata_o     (pal_wdata),
    .req_o           (req)
  );

  // Reads and writes in the same cycle are ordered correctly: the write
  // always belongs to a later input beat than the byte being read.
  dpu_palette_ram u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (req.valid && req.from_pal),
    .raddr_i (req.addr),
    .rdata_o (pal_rdata)
  );

  // Stage that waits out the palette read latency.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_pal_q <= req.from_pal;
    p1_pix_q <= req.pix;
  end

  always_comb begin
    push_pix     = p1_pix_q;
    push_pix.rgb = p1_pal_q ? pal_rdata : p1_pix_q.rgb;
  end

  dpu_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (p1_v_q),
    .data_i      (push_pix),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (head),
    .count_o     (fifo_count)
  );

  assign red_o          = head.rgb[23:16];
  assign green_o        = head.rgb[15:8];
  assign blue_o         = head.rgb[7:0];
  assign end_of_row_o   = head.eor;
  assign end_of_image_o = head.eoi;

endmodule
